// ===== rtl/sts_pkg.sv =====
package sts_pkg;

  localparam int DEF_LINE_WIDTH = 20;
  localparam int DEF_COL_WIDTH  = 16;
  localparam int OFFSET_WIDTH   = 24;
  localparam int LENGTH_WIDTH   = 16;
  localparam int VALUE_WIDTH    = 32;
  localparam int BYTE_WIDTH     = 8;
  localparam int KIND_WIDTH     = 5;
  localparam int QUEUE_DEPTH    = 4;

  localparam int KW_INT_LEN = 3;
  localparam int KW_RET_LEN = 6;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KW_NONE = 2'd0,
    KW_INT  = 2'd1,
    KW_RET  = 2'd2
  } kw_t;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_END     = 5'd0,
    KIND_IDENT   = 5'd1,
    KIND_NUMBER  = 5'd2,
    KIND_INT     = 5'd3,
    KIND_RETURN  = 5'd4,
    KIND_ASSIGN  = 5'd5,
    KIND_PLUS    = 5'd6,
    KIND_MINUS   = 5'd7,
    KIND_STAR    = 5'd8,
    KIND_SLASH   = 5'd9,
    KIND_LPAREN  = 5'd10,
    KIND_RPAREN  = 5'd11,
    KIND_LBRACE  = 5'd12,
    KIND_RBRACE  = 5'd13,
    KIND_SEMI    = 5'd14,
    KIND_COMMA   = 5'd15,
    KIND_UNKNOWN = 5'd16
  } kind_t;

  // Write strobes for the result queue: the second word is only written
  // together with the first.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic logic [7:0] kw_int_char(input logic [LENGTH_WIDTH-1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      16'd0:   ch = "i";
      16'd1:   ch = "n";
      16'd2:   ch = "t";
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_ret_char(input logic [LENGTH_WIDTH-1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      16'd0:   ch = "r";
      16'd1:   ch = "e";
      16'd2:   ch = "t";
      16'd3:   ch = "u";
      16'd4:   ch = "r";
      16'd5:   ch = "n";
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      "=":     k = KIND_ASSIGN;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ";":     k = KIND_SEMI;
      ",":     k = KIND_COMMA;
      CH_NUL:  k = KIND_END;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/sts_queue.sv =====
module sts_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sts_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  sts_pkg::push_t    push,
  input  logic [WIDTH-1:0]  wr_data0,
  input  logic [WIDTH-1:0]  wr_data1,
  output logic              room2,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [WIDTH-1:0]  rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] n_push;
  logic             pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign room2    = (count <= CNT_W'(DEPTH - 2));
  assign n_push   = CNT_W'(push.first) + CNT_W'(push.second);

  always_comb begin
    count_next = count + n_push - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr] <= wr_data0;
    end
    if (push.second) begin
      mem[PTR_W'(wr_ptr + 1'b1)] <= wr_data1;
    end
  end

endmodule

// ===== rtl/source_token_scanner.sv =====
// Channel  Dir  Word                                   Sideband
// s        in   tdata: ch                              tlast: end of input
// m        out  tdata: line, col, offset, length,      tuser: kind
//                      value, overflow, unknown byte   tlast: last result of item
//
// One source byte is scanned in the cycle it is accepted; its tokens enter a
// four-word result queue at that edge. A punctuation byte or the end of input
// that closes a pending word or number yields two words, and input is taken
// only while the queue has room for two, so the sustained rate is one byte per
// cycle unless the output side drains slower.
// Reset (synchronous) empties the queue and returns to line 1, column 1.
module source_token_scanner #(
  parameter int LINE_WIDTH = sts_pkg::DEF_LINE_WIDTH,
  parameter int COL_WIDTH  = sts_pkg::DEF_COL_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata,   // ch[7:0]
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // line, col, offset[23:0], length[15:0], value[31:0], overflow, unknown byte[7:0]
  output logic [((LINE_WIDTH + COL_WIDTH + 81 + 7) / 8) * 8 - 1:0] m_tdata,
  output logic [sts_pkg::KIND_WIDTH-1:0] m_tuser, // kind[4:0]
  output logic m_tlast
);

  localparam int OW = sts_pkg::OFFSET_WIDTH;
  localparam int LENW = sts_pkg::LENGTH_WIDTH;
  localparam int VW = sts_pkg::VALUE_WIDTH;
  localparam int BW = sts_pkg::BYTE_WIDTH;
  localparam int KW = sts_pkg::KIND_WIDTH;
  localparam int DW = LINE_WIDTH + COL_WIDTH + OW + LENW + VW + 1 + BW;
  localparam int TDATA_W = ((DW + 7) / 8) * 8;
  localparam int EW = DW + KW + 1;

  sts_pkg::mode_t mode, mode_next;
  sts_pkg::kw_t   kw, kw_next;
  logic [LINE_WIDTH-1:0] cur_line, cur_line_next, tok_line, tok_line_next;
  logic [COL_WIDTH-1:0]  cur_col, cur_col_next, tok_col, tok_col_next;
  logic [OW-1:0]         cur_offset, cur_offset_next, tok_offset, tok_offset_next;
  logic [LENW-1:0]       tok_length, tok_length_next;
  logic [VW-1:0]         num_accum, num_accum_next;
  logic                  num_sat, num_sat_next;

  logic        accept;
  logic [7:0]  c;
  logic        is_alpha, is_digit, is_space, is_word;
  logic        extend;
  logic [VW+3:0] acc10;

  logic           a_valid, b_valid;
  sts_pkg::kind_t a_kind, b_kind;
  logic [LENW-1:0] b_len;
  logic [BW-1:0]   b_unk;
  logic [DW-1:0]   a_data, b_data;

  sts_pkg::push_t push;
  logic [EW-1:0]  wr_data0, wr_data1, q_data;
  logic           room2;

  assign accept = s_tvalid && s_tready;
  assign s_tready = room2;
  assign c = s_tdata;

  assign is_alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  assign is_digit = (c >= "0" && c <= "9");
  assign is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
  assign is_word  = is_alpha || is_digit || (c == sts_pkg::CH_UNDERSCORE);

  // acc * 10 + digit, with four spare bits to see the overflow.
  assign acc10 = {1'b0, num_accum, 3'b000} + {3'b000, num_accum, 1'b0}
               + {{VW{1'b0}}, c[3:0]};

  always_comb begin
    priority if (mode == sts_pkg::MODE_WORD && kw == sts_pkg::KW_INT
                 && tok_length == LENW'(sts_pkg::KW_INT_LEN)) begin
      a_kind = sts_pkg::KIND_INT;
    end else if (mode == sts_pkg::MODE_WORD && kw == sts_pkg::KW_RET
                 && tok_length == LENW'(sts_pkg::KW_RET_LEN)) begin
      a_kind = sts_pkg::KIND_RETURN;
    end else if (mode == sts_pkg::MODE_NUMBER) begin
      a_kind = sts_pkg::KIND_NUMBER;
    end else begin
      a_kind = sts_pkg::KIND_IDENT;
    end
  end

  always_comb begin
    mode_next       = mode;
    kw_next         = kw;
    cur_line_next   = cur_line;
    cur_col_next    = cur_col;
    cur_offset_next = cur_offset;
    tok_line_next   = tok_line;
    tok_col_next    = tok_col;
    tok_offset_next = tok_offset;
    tok_length_next = tok_length;
    num_accum_next  = num_accum;
    num_sat_next    = num_sat;
    a_valid = 1'b0;
    b_valid = 1'b0;
    b_kind  = sts_pkg::KIND_END;
    b_len   = '0;
    b_unk   = '0;
    extend  = (mode == sts_pkg::MODE_WORD && is_word)
           || (mode == sts_pkg::MODE_NUMBER && is_digit);

    if (s_tlast) begin
      a_valid   = (mode != sts_pkg::MODE_IDLE);
      b_valid   = 1'b1;
      mode_next = sts_pkg::MODE_IDLE;
    end else begin
      if (extend) begin
        if (mode == sts_pkg::MODE_WORD) begin
          if (kw == sts_pkg::KW_INT && (tok_length >= LENW'(sts_pkg::KW_INT_LEN)
              || c != sts_pkg::kw_int_char(tok_length))) begin
            kw_next = sts_pkg::KW_NONE;
          end
          if (kw == sts_pkg::KW_RET && (tok_length >= LENW'(sts_pkg::KW_RET_LEN)
              || c != sts_pkg::kw_ret_char(tok_length))) begin
            kw_next = sts_pkg::KW_NONE;
          end
        end else begin
          if (acc10[VW+3:VW] != '0) begin
            num_accum_next = '1;
            num_sat_next   = 1'b1;
          end else begin
            num_accum_next = acc10[VW-1:0];
          end
        end
        if (tok_length != '1) begin
          tok_length_next = tok_length + 1'b1;
        end
      end else begin
        a_valid   = (mode != sts_pkg::MODE_IDLE);
        mode_next = sts_pkg::MODE_IDLE;
        priority if (is_space) begin
          // Whitespace only moves the position.
        end else if (is_alpha || c == sts_pkg::CH_UNDERSCORE) begin
          mode_next       = sts_pkg::MODE_WORD;
          tok_line_next   = cur_line;
          tok_col_next    = cur_col;
          tok_offset_next = cur_offset;
          tok_length_next = LENW'(1);
          kw_next = (c == "i") ? sts_pkg::KW_INT :
                    (c == "r") ? sts_pkg::KW_RET : sts_pkg::KW_NONE;
        end else if (is_digit) begin
          mode_next       = sts_pkg::MODE_NUMBER;
          tok_line_next   = cur_line;
          tok_col_next    = cur_col;
          tok_offset_next = cur_offset;
          tok_length_next = LENW'(1);
          num_accum_next  = VW'(c[3:0]);
          num_sat_next    = 1'b0;
        end else begin
          b_valid = 1'b1;
          b_kind  = sts_pkg::punct_kind(c);
          b_len   = (b_kind == sts_pkg::KIND_END) ? LENW'(0) : LENW'(1);
          b_unk   = (b_kind == sts_pkg::KIND_UNKNOWN) ? c : '0;
        end
      end

      if (cur_offset != '1) begin
        cur_offset_next = cur_offset + 1'b1;
      end
      if (c == sts_pkg::CH_NEWLINE) begin
        if (cur_line != '1) begin
          cur_line_next = cur_line + 1'b1;
        end
        cur_col_next = COL_WIDTH'(1);
      end else if (cur_col != '1) begin
        cur_col_next = cur_col + 1'b1;
      end
    end
  end

  // The pending token is reported from its saved start; the byte's own token
  // from the position before this byte.
  assign a_data = {{BW{1'b0}},
                   (mode == sts_pkg::MODE_NUMBER) ? num_sat : 1'b0,
                   (mode == sts_pkg::MODE_NUMBER) ? num_accum : {VW{1'b0}},
                   tok_length, tok_offset, tok_col, tok_line};
  assign b_data = {b_unk, 1'b0, {VW{1'b0}}, b_len, cur_offset, cur_col, cur_line};

  assign push.first  = accept && (a_valid || b_valid);
  assign push.second = accept && a_valid && b_valid;
  assign wr_data0 = a_valid ? {~b_valid, a_kind, a_data} : {1'b1, b_kind, b_data};
  assign wr_data1 = {1'b1, b_kind, b_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= sts_pkg::MODE_IDLE;
      kw         <= sts_pkg::KW_NONE;
      cur_line   <= LINE_WIDTH'(1);
      cur_col    <= COL_WIDTH'(1);
      cur_offset <= '0;
      tok_line   <= LINE_WIDTH'(1);
      tok_col    <= COL_WIDTH'(1);
      tok_offset <= '0;
      tok_length <= '0;
      num_accum  <= '0;
      num_sat    <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      kw         <= kw_next;
      cur_line   <= cur_line_next;
      cur_col    <= cur_col_next;
      cur_offset <= cur_offset_next;
      tok_line   <= tok_line_next;
      tok_col    <= tok_col_next;
      tok_offset <= tok_offset_next;
      tok_length <= tok_length_next;
      num_accum  <= num_accum_next;
      num_sat    <= num_sat_next;
    end
  end

  sts_queue #(
    .WIDTH (EW),
    .DEPTH (sts_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data0 (wr_data0),
    .wr_data1 (wr_data1),
    .room2    (room2),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_data  (q_data)
  );

  assign m_tdata = TDATA_W'(q_data[DW-1:0]);
  assign m_tuser = q_data[DW +: KW];
  assign m_tlast = q_data[EW-1];

endmodule

// ===== rtl/sts_checker.sv =====
module sts_checker #(
  parameter int LINE_WIDTH = sts_pkg::DEF_LINE_WIDTH,
  parameter int COL_WIDTH  = sts_pkg::DEF_COL_WIDTH
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic [7:0] s_tdata,
  input logic s_tlast,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((LINE_WIDTH + COL_WIDTH + 81 + 7) / 8) * 8 - 1:0] m_tdata,
  input logic [sts_pkg::KIND_WIDTH-1:0] m_tuser,
  input logic m_tlast
);

  localparam int LEN_LSB = LINE_WIDTH + COL_WIDTH + sts_pkg::OFFSET_WIDTH;
  localparam int VAL_LSB = LEN_LSB + sts_pkg::LENGTH_WIDTH;
  localparam int OVF_BIT = VAL_LSB + sts_pkg::VALUE_WIDTH;

  logic [sts_pkg::LENGTH_WIDTH-1:0] len_f;
  logic [sts_pkg::VALUE_WIDTH-1:0]  val_f;
  logic in_seen;

  assign len_f = m_tdata[LEN_LSB +: sts_pkg::LENGTH_WIDTH];
  assign val_f = m_tdata[VAL_LSB +: sts_pkg::VALUE_WIDTH];
  assign in_seen = s_tvalid && s_tready && (s_tdata != 8'hFF || !s_tlast || s_tlast);

  // The queue comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result word changed");

  // An end token is empty and always closes the results of its byte.
  a_end_token: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == sts_pkg::KIND_END |-> len_f == '0 && m_tlast)
    else $error("malformed end token");

  a_value_only_number: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != sts_pkg::KIND_NUMBER |-> val_f == '0 && !m_tdata[OVF_BIT])
    else $error("number value on a non-number token");

  // Nothing is produced without a byte having come in.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !in_seen && !m_tvalid |=> !m_tvalid)
    else $error("result word appeared without input");

endmodule

bind source_token_scanner sts_checker #(
  .LINE_WIDTH (LINE_WIDTH),
  .COL_WIDTH  (COL_WIDTH)
) u_sts_checker (.*);
